// File: sv/srfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srfv_pkg;

  localparam int SAMPLE_W = 32;
  localparam int GAIN_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int OVERSAMPLE_DEF = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd3;

  localparam logic [31:0] PHASE_RESET = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h10_0000;
  localparam logic [GAIN_W-1:0] GAIN_CAP = 24'hA0_0000;

  // Reciprocal 2^44 / den in Q.20, clamped at 128.0.
  localparam int RECIP_W = 28;
  localparam logic [RECIP_W-1:0] RECIP_CAP = 28'h800_0000;
  localparam int DIV_STEPS = 27;
  localparam int DIV_CNT_W = 5;
  localparam logic [31:0] DIV_INIT = 32'h0002_0000;
  localparam logic [31:0] DEN_CLAMP = 32'h0002_0000;
  localparam logic [31:0] EPS_Q24 = 32'd1678;

  localparam logic signed [31:0] K_NEW = 32'sd125829;
  localparam logic signed [31:0] K_OLD = 32'sd922747;

endpackage

`default_nettype wire

// File: sv/srfv_div.sv
`timescale 1ns / 1ps
`default_nettype none

module srfv_div
  import srfv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [31:0]          den,
  output logic                      done,
  output logic [DIV_STEPS-1:0]      quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [32:0]          trial;

  // Restoring division of 2^44 by den, one quotient bit per cycle. The
  // remainder starts at 2^17, which is below den whenever this unit runs.
  assign trial = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= DIV_INIT;
        quo  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
          quo <= {quo[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[DIV_STEPS-2:0], 1'b0};
        end
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/saw_resonant_filter_voice.sv
`timescale 1ns / 1ps
`default_nettype none

// Sawtooth voice through a two-pole resonant low-pass filter. Each request on
// the input channel produces one Q8.24 output sample: the block runs
// OVERSAMPLE filter substeps y = a*y1 + b*y2 + c*saw, tracks the block peak,
// and emits the last y times the current gain, saturated, with a clip flag.
// When the request is flagged end_of_block, the gain is then recomputed from
// the block peak (0.12/(peak+0.0001) + 0.88*gain, capped at 10) and the peak
// trackers are cleared. All multiplications go through one registered 32x32
// multiplier under a small sequencer. Each of the OVERSAMPLE substeps (four
// by default) needs three multiplier passes and a history update; then the
// output product is formed, and the output state waits while the previous
// result is unclaimed. An end-of-block request then also runs the bit-serial
// reciprocal divider and two more multiplier passes before the block is
// ready again. The input channel is not ready while a request is being worked
// on. The output is held in a register, so a result may wait downstream while
// the next request is already computing. Coefficients must be written through
// the configuration port only while the block is idle; the block itself does
// not enforce this.

module saw_resonant_filter_voice
  import srfv_pkg::*;
#(
  parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       end_of_block,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            clipped
);

  localparam int SUB_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MA   = 4'd1;
  localparam logic [3:0] S_MB   = 4'd2;
  localparam logic [3:0] S_MC   = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_GM   = 4'd5;
  localparam logic [3:0] S_GO   = 4'd6;
  localparam logic [3:0] S_PK   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DIVW = 4'd9;
  localparam logic [3:0] S_GK1  = 4'd10;
  localparam logic [3:0] S_GK2  = 4'd11;
  localparam logic [3:0] S_GK3  = 4'd12;

  logic [3:0]               state;
  logic [SUB_W-1:0]         sub_cnt;
  logic                     eob;

  logic signed [31:0]       coef_a;
  logic signed [31:0]       coef_b;
  logic signed [31:0]       coef_c;
  logic [31:0]              phase_step;

  logic [31:0]              saw_phase;
  logic signed [31:0]       filter_prev1;
  logic signed [31:0]       filter_prev2;
  logic signed [31:0]       peak_high;
  logic signed [31:0]       peak_low;
  logic [GAIN_W-1:0]        gain;

  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [63:0]       prod;
  logic signed [45:0]       acc;
  logic [31:0]              den;
  logic [RECIP_W-1:0]       recip;

  logic signed [63:0]       prod_r28;
  logic signed [45:0]       term_ext;
  logic signed [45:0]       fsum;
  logic signed [31:0]       y_sat;
  logic signed [63:0]       prod_r20;
  logic signed [43:0]       out_wide;
  logic signed [31:0]       out_sat;
  logic                     out_clip;
  logic signed [32:0]       ph33;
  logic signed [32:0]       neg_low;
  logic signed [32:0]       pk;
  logic [45:0]              gsum;
  logic [25:0]              g_new;

  logic                     div_start;
  logic                     div_done;
  logic [DIV_STEPS-1:0]     div_quo;

  assign in_ready = (state == S_IDLE) && !rst;

  // Operand selection for the shared multiplier. The product is registered,
  // so a state loads operands and the following state consumes the result.
  always_comb begin
    case (state)
      S_MA: begin
        mul_a = coef_a;
        mul_b = filter_prev1;
      end
      S_MB: begin
        mul_a = coef_b;
        mul_b = filter_prev2;
      end
      S_MC: begin
        // The saw value is the phase shifted right by eight, sign kept.
        mul_a = coef_c;
        mul_b = {{8{saw_phase[31]}}, saw_phase[31:8]};
      end
      S_GK1: begin
        mul_a = K_NEW;
        mul_b = {{(32 - RECIP_W){1'b0}}, recip};
      end
      S_GK2: begin
        mul_a = K_OLD;
        mul_b = {{(32 - GAIN_W){1'b0}}, gain};
      end
      default: begin
        // Output product; it also stays stable while the output waits.
        mul_a = filter_prev1;
        mul_b = {{(32 - GAIN_W){1'b0}}, gain};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Each filter term is rounded to Q8.24, half toward plus infinity.
  always_comb begin
    prod_r28 = prod + 64'sd134217728;
    term_ext = {{10{prod_r28[63]}}, prod_r28[63:28]};
    fsum     = acc + term_ext;
    if (fsum > 46'sd2147483647) begin
      y_sat = 32'sh7fff_ffff;
    end else if (fsum < -46'sd2147483648) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = fsum[31:0];
    end
  end

  // Output sample: y times gain rounded from Q.44 to Q8.24 and saturated.
  always_comb begin
    prod_r20 = prod + 64'sd524288;
    out_wide = prod_r20[63:20];
    out_clip = 1'b1;
    if (out_wide > 44'sd2147483647) begin
      out_sat = 32'sh7fff_ffff;
    end else if (out_wide < -44'sd2147483648) begin
      out_sat = 32'sh8000_0000;
    end else begin
      out_sat  = out_wide[31:0];
      out_clip = 1'b0;
    end
  end

  // Block peak is the larger magnitude of the two trackers.
  always_comb begin
    ph33    = {peak_high[31], peak_high};
    neg_low = 33'sd0 - {peak_low[31], peak_low};
    pk      = (ph33 > neg_low) ? ph33 : neg_low;
  end

  // New gain in Q4.20: weighted sum of the reciprocal and the old gain.
  always_comb begin
    gsum  = 46'(acc) + prod[45:0] + 46'd524288;
    g_new = gsum[45:20];
  end

  // A denominator at or below 2^17 gives a reciprocal at or above the clamp,
  // so the divider is only started for larger ones.
  assign div_start = (state == S_DIV) && (den > DEN_CLAMP);

  srfv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sub_cnt      <= '0;
      eob          <= 1'b0;
      out_valid    <= 1'b0;
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      phase_step   <= '0;
      saw_phase    <= PHASE_RESET;
      filter_prev1 <= '0;
      filter_prev2 <= '0;
      peak_high    <= '0;
      peak_low     <= '0;
      gain         <= GAIN_ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_A:     coef_a <= cfg_data;
          REG_COEF_B:     coef_b <= cfg_data;
          REG_COEF_C:     coef_c <= cfg_data;
          REG_PHASE_STEP: phase_step <= cfg_data;
          default: ;
        endcase
      end

      // In the output state a claimed result is replaced by the new one.
      if (out_valid && out_ready && (state != S_GO)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            eob     <= end_of_block;
            sub_cnt <= '0;
            state   <= S_MA;
          end
        end
        S_MA: begin
          state <= S_MB;
        end
        S_MB: begin
          acc   <= term_ext;
          state <= S_MC;
        end
        S_MC: begin
          acc   <= fsum;
          state <= S_UPD;
        end
        S_UPD: begin
          // The saturated value enters both the history and the peaks.
          filter_prev2 <= filter_prev1;
          filter_prev1 <= y_sat;
          saw_phase    <= saw_phase + phase_step;
          if (y_sat > peak_high) begin
            peak_high <= y_sat;
          end
          if (y_sat < peak_low) begin
            peak_low <= y_sat;
          end
          if (sub_cnt == SUB_W'(OVERSAMPLE - 1)) begin
            state <= S_GM;
          end else begin
            sub_cnt <= sub_cnt + 1'b1;
            state   <= S_MA;
          end
        end
        S_GM: begin
          state <= S_GO;
        end
        S_GO: begin
          // Wait here only while the previous result is still unclaimed.
          if (!out_valid || out_ready) begin
            sample_out <= out_sat;
            clipped    <= out_clip;
            out_valid  <= 1'b1;
            state      <= eob ? S_PK : S_IDLE;
          end
        end
        S_PK: begin
          den   <= pk[31:0] + EPS_Q24;
          state <= S_DIV;
        end
        S_DIV: begin
          if (den <= DEN_CLAMP) begin
            recip <= RECIP_CAP;
            state <= S_GK1;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            recip <= {1'b0, div_quo};
            state <= S_GK1;
          end
        end
        S_GK1: begin
          state <= S_GK2;
        end
        S_GK2: begin
          acc   <= prod[45:0];
          state <= S_GK3;
        end
        S_GK3: begin
          if (g_new > 26'(GAIN_CAP)) begin
            gain <= GAIN_CAP;
          end else begin
            gain <= g_new[GAIN_W-1:0];
          end
          peak_high <= '0;
          peak_low  <= '0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The gain never leaves its capped range.
  a_gain_cap: assert property (@(posedge clk) disable iff (rst)
    gain <= GAIN_CAP)
    else $error("gain above cap");

  // The trackers hold max(0, y) and min(0, y).
  a_peak_sign: assert property (@(posedge clk) disable iff (rst)
    !peak_high[31] && (peak_low[31] || (peak_low == 32'sd0)))
    else $error("peak tracker sign wrong");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider done outside wait state");

  // An accepted request blocks the input for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srfv_pkg::*;

  // The watchdog gives up after this many cycles in which neither channel
  // moves a request. The slowest legal stretch is a configuration pause,
  // or a sender gap plus an end-of-block request plus the longest output
  // stall. This limit is many times that.
  localparam int unsigned IDLE_LIMIT = 4000;

  // An end-of-block request keeps the block busy with the gain update after
  // its sample has already come out. Before a register write we let this
  // many cycles pass so that the update is surely done.
  localparam int unsigned SETTLE_CYCLES = 64;

  localparam longint SAMPLE_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAMPLE_MIN = -64'sh0000_0000_8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam int unsigned MAX_PRINTED_ERRORS = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } voice_sample_t;

  // Inputs of the block all start at known values.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_COEF_A;
  logic [31:0]                cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       end_of_block = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  saw_resonant_filter_voice i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_block (end_of_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .clipped      (clipped)
  );

  always #5 clk = ~clk;

  // Samples that the voice should produce, oldest first.
  voice_sample_t expected_samples[$];

  int unsigned mismatches = 0;
  int unsigned samples_checked = 0;
  int unsigned burst_left = 0;

  // Our own copy of the voice: coefficients, filter history, peak trackers
  // and gain kept as 64-bit signed values so that no intermediate product
  // can overflow, and the oscillator phase and step as 32-bit vectors.
  longint      coef_a_q;
  longint      coef_b_q;
  longint      coef_c_q;
  logic [31:0] phase_step_q;
  logic [31:0] saw_phase_q;
  longint      filter_y1;
  longint      filter_y2;
  longint      peak_hi;
  longint      peak_lo;
  longint      gain_q;

  task automatic reset_voice_model();
    coef_a_q = 0;
    coef_b_q = 0;
    coef_c_q = 0;
    phase_step_q = '0;
    saw_phase_q = PHASE_RESET;
    filter_y1 = 0;
    filter_y2 = 0;
    peak_hi = 0;
    peak_lo = 0;
    gain_q = longint'(GAIN_ONE);
  endtask

  // Shift right by n with rounding half toward plus infinity.
  function automatic longint round_shift(longint p, int n);
    return (p + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // Runs the oversampled filter for one request, queues the sample that it
  // must produce, and applies the gain update when the request ends a block.
  task automatic predict_voice_sample(input logic eob);
    longint        saw;
    longint        y;
    longint        prod;
    longint        pk;
    longint        recip;
    longint        g;
    voice_sample_t s;
    y = 0;
    for (int k = 0; k < OVERSAMPLE_DEF; k++) begin
      // The saw is the phase read as a signed cycle fraction, floored to Q8.24.
      saw = longint'($signed(saw_phase_q)) >>> 8;
      y = clamp_sample(round_shift(coef_a_q * filter_y1, 28)
                       + round_shift(coef_b_q * filter_y2, 28)
                       + round_shift(coef_c_q * saw, 28));
      filter_y2 = filter_y1;
      filter_y1 = y;
      saw_phase_q = saw_phase_q + phase_step_q;
      if (y > peak_hi) peak_hi = y;
      if (y < peak_lo) peak_lo = y;
    end
    prod = round_shift(y * gain_q, 20);
    s.clip = (prod > SAMPLE_MAX) || (prod < SAMPLE_MIN);
    s.sample = SAMPLE_W'(clamp_sample(prod));
    expected_samples.push_back(s);
    if (eob) begin
      // The gain moves toward 1/peak; a silent block drives the
      // reciprocal into its clamp and the gain onto its cap.
      pk = (peak_hi > -peak_lo) ? peak_hi : -peak_lo;
      recip = (longint'(1) <<< 44) / (pk + longint'(EPS_Q24));
      if (recip > longint'(RECIP_CAP)) recip = longint'(RECIP_CAP);
      g = (longint'(K_NEW) * recip + longint'(K_OLD) * gain_q
           + (longint'(1) <<< 19)) >>> 20;
      if (g > longint'(GAIN_CAP)) g = longint'(GAIN_CAP);
      gain_q = g;
      peak_hi = 0;
      peak_lo = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (mismatches < MAX_PRINTED_ERRORS) begin
      $display("ERROR sample %0d: %s expected %0d, got %0d at %0t",
               samples_checked, what, want, got, $realtime);
    end
    mismatches++;
  endtask

  // Every sample leaving the block is compared with the oldest prediction.
  always @(posedge clk) begin : check_samples
    voice_sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample, value", 0, sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want.sample) begin
          report_mismatch("sample_out", want.sample, sample_out);
        end
        if (clipped !== want.clip) begin
          report_mismatch("clipped", want.clip, clipped);
        end
      end
      samples_checked++;
    end
  end

  // The receiver switches at random between always ready, ready at random,
  // and long stalls alternating with long ready stretches.
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(100, 400);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_hold_left == 0) begin
          out_ready <= ~out_ready;
          rx_hold_left = $urandom_range(1, 40);
        end else begin
          rx_hold_left--;
        end
      end
    endcase
  end

  // Watchdog: a run in which no request moves for too long has hung.
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Sends one request. The sender works in bursts: within a burst valid
  // stays high from one request to the next, and between bursts it drops
  // for a random gap. Called and left at a falling edge.
  task automatic send_request(input logic eob);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    end_of_block <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_voice_sample(eob);
    burst_left--;
    @(negedge clk);
  endtask

  // Stops sending, waits for every predicted sample, then lets the block
  // finish any gain update still in progress.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers on consecutive cycles, only while idle.
  task automatic program_filter(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] step);
    cfg_we <= 1'b1;
    cfg_index <= REG_COEF_A;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= REG_COEF_B;
    cfg_data <= b;
    @(negedge clk);
    cfg_index <= REG_COEF_C;
    cfg_data <= c;
    @(negedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data <= step;
    @(negedge clk);
    cfg_we <= 1'b0;
    coef_a_q = longint'($signed(a));
    coef_b_q = longint'($signed(b));
    coef_c_q = longint'($signed(c));
    phase_step_q = step;
  endtask

  // Sends a block of n requests with only the last one ending the block.
  task automatic send_block(input int unsigned n);
    for (int unsigned k = 1; k <= n; k++) begin
      send_request(k == n);
    end
  endtask

  // With every register at its reset value of zero the filter stays silent.
  // The end of such a block divides by the bare epsilon, so the reciprocal
  // hits its clamp and the gain lands on its cap of ten.
  task automatic test_reset_values();
    send_block(4);
    send_request(1'b0);
    wait_until_idle();
  endtask

  // Register extremes: full-scale coefficients of both signs blow the
  // filter into saturation on both rails, which also drives the peak
  // trackers to full scale. Phase steps of zero, one half and almost a full
  // cycle exercise the phase wrap. With the gain at its cap the output
  // clips as well.
  task automatic test_extreme_settings();
    program_filter(S32_MAX, S32_MAX, S32_MAX, 32'hFFFF_FFFF);
    send_block(4);
    wait_until_idle();
    program_filter(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    send_block(4);
    wait_until_idle();
    program_filter(S32_MAX, S32_MIN, S32_MIN, 32'h0000_0000);
    send_block(3);
    wait_until_idle();
    // A quiet, well-behaved filter so that the gain recovers from the
    // saturated blocks without hitting the reciprocal clamp.
    program_filter(32'h1000_0000, 32'h0000_0000, 32'h0100_0000, 32'h0000_0001);
    send_block(3);
    send_block(2);
    wait_until_idle();
  endtask

  // Musical settings: a resonant low-pass with poles just inside the unit
  // circle, driven by an audio-rate saw, run as whole blocks of random
  // length so that the gain control loop settles and tracks.
  task automatic test_resonant_voices();
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  c;
    logic [31:0]  step;
    int unsigned  b_mag;
    int unsigned  sent;
    int unsigned  n;
    for (int v = 0; v < 10; v++) begin
      // Stable when |b| < 1 and |a| < 1 - b, with b = -b_mag.
      b_mag = $urandom_range(32'h0CCC_CCCC, 32'h0FD7_0A3D);
      b = -b_mag;
      a = $urandom_range(32'h1000_0000, 32'h1000_0000 + b_mag - 32'h0040_0000);
      c = $urandom_range(32'h0040_0000, 32'h0400_0000);
      step = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom_range(32'h0010_0000, 32'h1000_0000);
      program_filter(a, b, c, step);
      sent = 0;
      while (sent < 124) begin
        n = $urandom_range(1, 48);
        send_block(n);
        sent += n;
      end
      wait_until_idle();
    end
  endtask

  // Arbitrary register values and end-of-block flags on any request,
  // including back-to-back ends of block and long runs with none at all.
  task automatic test_noisy_sequences();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    for (int v = 0; v < 4; v++) begin
      a = $urandom();
      b = $urandom();
      c = $urandom();
      // Some settings keep a and b small so the filter does not simply sit
      // on a rail, while c and the phase step still span their full range.
      if (v[0]) begin
        a = {{4{a[31]}}, a[27:0]};
        b = {{5{b[31]}}, b[26:0]};
      end
      program_filter(a, b, c, $urandom());
      for (int k = 0; k < 110; k++) begin
        send_request($urandom_range(0, 7) == 0);
      end
      wait_until_idle();
    end
  endtask

  initial begin
    reset_voice_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_extreme_settings();
    test_resonant_voices();
    test_noisy_sequences();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
